@@ sv/wlan_rx_frame_classifier_core_macros.svh @@
// Assertion helpers shared by the classifier RTL.
`ifndef WLAN_RX_FRAME_CLASSIFIER_CORE_MACROS_SVH
`define WLAN_RX_FRAME_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WRFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/wrfc_pkg.sv @@
package wrfc_pkg;

  // capture length caps
  localparam int unsigned EAPOL_CAP  = 256;
  localparam int unsigned BEACON_CAP = 200;
  localparam int unsigned ASSOC_CAP  = 64;
  localparam int unsigned AUTH_CAP   = 40;

  localparam int POS_W = 12;
  localparam int LEN_W = POS_W + 1;
  localparam int CAP_LEN_W = 9;
  localparam int CAP_START_W = 6;
  localparam int CNT_W = 32;
  localparam int NUM_COUNTERS = 6;
  localparam int ADDR_W = 48;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // frame-control byte codes
  localparam logic [7:0] FC_BEACON     = 8'h80;
  localparam logic [7:0] FC_PROBE_RESP = 8'h50;
  localparam logic [7:0] FC_AUTH       = 8'hb0;
  localparam logic [7:0] FC_DEAUTH     = 8'hc0;
  localparam logic [7:0] FC_ASSOC_RESP = 8'h10;
  localparam logic [7:0] FC_TYPE_MASK  = 8'h0c;
  localparam logic [7:0] FC_TYPE_DATA  = 8'h08;

  // LLC/SNAP + EAPOL ethertype
  localparam logic [7:0] SNAP_SAP      = 8'haa;
  localparam logic [7:0] EAPOL_TYPE_HI = 8'h88;
  localparam logic [7:0] EAPOL_TYPE_LO = 8'h8e;

  localparam int MIN_FRAME_LEN  = 24;
  localparam int MIN_BEACON_LEN = 40;
  localparam int ADDR1_FIRST    = 4;
  localparam int ADDR1_LAST     = 9;
  localparam int ADDR2_FIRST    = 10;
  localparam int ADDR2_LAST     = 15;
  localparam int SNAP_FIRST_POS = 31;
  localparam int SNAP_LAST_POS  = 46;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_REARM = 1'b1;

  // register index = paddr[3]
  localparam logic REG_STATION = 1'b0;
  localparam logic REG_BSSID   = 1'b1;

  // counter slots
  localparam int CNT_FRAMES        = 0;
  localparam int CNT_BEACON_AP     = 1;
  localparam int CNT_PROBE_US      = 2;
  localparam int CNT_PROBE_AP      = 3;
  localparam int CNT_AUTH_AP       = 4;
  localparam int CNT_DEAUTH_AP     = 5;

  typedef enum logic [2:0] {
    KIND_SHORT,
    KIND_BEACON,
    KIND_PROBE_RESP,
    KIND_AUTH,
    KIND_DEAUTH,
    KIND_ASSOC_RESP,
    KIND_DATA,
    KIND_OTHER
  } frame_kind_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_BEACON,
    CAP_AUTH_RESP,
    CAP_ASSOC_RESP,
    CAP_EAPOL
  } capture_kind_t;

endpackage

@@ sv/wrfc_byte_if.sv @@
interface wrfc_byte_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, command, frame_byte, last_byte, input ready);
  modport sink   (input valid, command, frame_byte, last_byte, output ready);
endinterface

@@ sv/wrfc_result_if.sv @@
interface wrfc_result_if;
  logic                                valid;
  logic                                ready;
  wrfc_pkg::frame_kind_t               frame_kind;
  logic                                from_ap;
  logic                                to_us;
  wrfc_pkg::capture_kind_t             capture_kind;
  logic [wrfc_pkg::CAP_START_W-1:0]    capture_start;
  logic [wrfc_pkg::CAP_LEN_W-1:0]      capture_len;
  logic [wrfc_pkg::CNT_W-1:0]          frames_seen;
  logic [wrfc_pkg::CNT_W-1:0]          beacons_from_ap;
  logic [wrfc_pkg::CNT_W-1:0]          probe_resp_to_us;
  logic [wrfc_pkg::CNT_W-1:0]          probe_resp_from_ap;
  logic [wrfc_pkg::CNT_W-1:0]          auth_from_ap;
  logic [wrfc_pkg::CNT_W-1:0]          deauth_from_ap;

  modport source (output valid, frame_kind, from_ap, to_us, capture_kind, capture_start,
                  capture_len, frames_seen, beacons_from_ap, probe_resp_to_us,
                  probe_resp_from_ap, auth_from_ap, deauth_from_ap, input ready);
  modport sink   (input valid, frame_kind, from_ap, to_us, capture_kind, capture_start,
                  capture_len, frames_seen, beacons_from_ap, probe_resp_to_us,
                  probe_resp_from_ap, auth_from_ap, deauth_from_ap, output ready);
endinterface

@@ sv/wlan_rx_frame_classifier_core.sv @@
// Latency: a frame's result beat is valid the cycle after its last byte is accepted.
// Throughput: one byte or re-arm beat per cycle; bytes flow back to back. Any input beat
//   stalls only while the previous result beat sits unaccepted in the output register.
// Reset (rst, synchronous, active high): frame tracking restarts, capture flags and
//   counters clear, both address registers read zero, no result beat pending.
`include "wlan_rx_frame_classifier_core_macros.svh"

module wlan_rx_frame_classifier_core (
  input  logic                clk,
  input  logic                rst,
  wrfc_byte_if.sink           byte_ch,
  wrfc_result_if.source       result_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam int POS_W = wrfc_pkg::POS_W;
  localparam int LEN_W = wrfc_pkg::LEN_W;
  localparam int CNT_W = wrfc_pkg::CNT_W;
  localparam int NCNT  = wrfc_pkg::NUM_COUNTERS;
  localparam int AW    = wrfc_pkg::ADDR_W;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, 64-bit data, register i at byte 8*i)
  // ---------------------------------------------------------------------------
  logic [AW-1:0] station_address;
  logic [AW-1:0] bssid;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
      bssid           <= '0;
    end else if (cfg_write) begin
      case (paddr[3])
        wrfc_pkg::REG_STATION: station_address <= pwdata[AW-1:0];
        wrfc_pkg::REG_BSSID:   bssid           <= pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      wrfc_pkg::REG_STATION: prdata = {{(64-AW){1'b0}}, station_address};
      wrfc_pkg::REG_BSSID:   prdata = {{(64-AW){1'b0}}, bssid};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-frame tracking state
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] byte_position;
  logic [7:0]       control_byte;
  logic             dest_match;
  logic             source_match;
  logic [55:0]      byte_window;      // seven previous bytes; newest in [7:0]
  logic             snap_found;
  logic [5:0]       snap_body_start;
  logic             beacon_taken;
  logic             auth_taken;
  logic             assoc_taken;
  logic [CNT_W-1:0] frame_counters [NCNT];

  // Output register
  logic                    out_valid;
  wrfc_pkg::frame_kind_t   out_kind;
  logic                    out_from_ap;
  logic                    out_to_us;
  wrfc_pkg::capture_kind_t out_cap_kind;
  logic [5:0]              out_cap_start;
  logic [8:0]              out_cap_len;

  // Handshake. A new result can only be produced once the held one is taken, so
  // the counters stay put while a result waits and drive the beat directly.
  logic in_accept;
  logic is_rearm;
  logic is_last;

  assign byte_ch.ready = !out_valid || result_ch.ready;
  assign in_accept     = byte_ch.valid && byte_ch.ready;
  assign is_rearm      = byte_ch.command == wrfc_pkg::CMD_REARM;
  assign is_last       = !is_rearm && byte_ch.last_byte;

  // ---------------------------------------------------------------------------
  // Byte step: address compare, SNAP search, position advance
  // ---------------------------------------------------------------------------
  logic [7:0]       b;
  logic             advance;
  logic [POS_W-1:0] a1_off;
  logic [POS_W-1:0] a2_off;
  logic [7:0]       sta_byte;
  logic [7:0]       ap_byte;
  logic             in_addr1;
  logic             in_addr2;
  logic             in_snap_range;
  logic             snap_hit;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       control_byte_next;
  logic             dest_match_next;
  logic             source_match_next;
  logic             snap_found_next;
  logic [5:0]       snap_body_start_next;
  logic [LEN_W-1:0] len;

  always_comb begin
    b       = byte_ch.frame_byte;
    advance = byte_position != wrfc_pkg::POS_MAX;

    a1_off   = byte_position - POS_W'(wrfc_pkg::ADDR1_FIRST);
    a2_off   = byte_position - POS_W'(wrfc_pkg::ADDR2_FIRST);
    sta_byte = station_address[{a1_off[2:0], 3'b000} +: 8];
    ap_byte  = bssid[{a2_off[2:0], 3'b000} +: 8];

    in_addr1 = advance && byte_position >= POS_W'(wrfc_pkg::ADDR1_FIRST)
                       && byte_position <= POS_W'(wrfc_pkg::ADDR1_LAST);
    in_addr2 = advance && byte_position >= POS_W'(wrfc_pkg::ADDR2_FIRST)
                       && byte_position <= POS_W'(wrfc_pkg::ADDR2_LAST);
    in_snap_range = byte_position >= POS_W'(wrfc_pkg::SNAP_FIRST_POS)
                 && byte_position <= POS_W'(wrfc_pkg::SNAP_LAST_POS);

    control_byte_next = (advance && byte_position == '0) ? b : control_byte;
    dest_match_next   = dest_match   && !(in_addr1 && sta_byte != b);
    source_match_next = source_match && !(in_addr2 && ap_byte != b);

    // aa aa xx xx xx xx 88 8e ending at this byte, first hit only
    snap_hit = advance && !snap_found && in_snap_range && dest_match && source_match
            && (control_byte & wrfc_pkg::FC_TYPE_MASK) == wrfc_pkg::FC_TYPE_DATA
            && byte_window[55:48] == wrfc_pkg::SNAP_SAP
            && byte_window[47:40] == wrfc_pkg::SNAP_SAP
            && byte_window[7:0]   == wrfc_pkg::EAPOL_TYPE_HI
            && b                  == wrfc_pkg::EAPOL_TYPE_LO;
    snap_found_next      = snap_found || snap_hit;
    snap_body_start_next = snap_hit ? byte_position[5:0] + 6'd1 : snap_body_start;

    byte_position_next = advance ? byte_position + POS_W'(1) : byte_position;
    len                = {1'b0, byte_position} + LEN_W'(1);
  end

  // ---------------------------------------------------------------------------
  // End-of-frame classification, counters and capture choice
  // ---------------------------------------------------------------------------
  logic                    long_frame;
  logic                    fa;
  logic                    tu;
  wrfc_pkg::frame_kind_t   kind;
  wrfc_pkg::capture_kind_t cap_kind;
  logic [5:0]              cap_start;
  logic [LEN_W-1:0]        cap_len;
  logic [LEN_W-1:0]        eapol_len;
  logic [NCNT-1:0]         cnt_inc;
  logic                    beacon_taken_next;
  logic                    auth_taken_next;
  logic                    assoc_taken_next;

  always_comb begin
    long_frame = len >= LEN_W'(wrfc_pkg::MIN_FRAME_LEN);
    fa = long_frame && source_match_next;
    tu = long_frame && dest_match_next;

    if (!long_frame)                                      kind = wrfc_pkg::KIND_SHORT;
    else if (control_byte_next == wrfc_pkg::FC_BEACON)     kind = wrfc_pkg::KIND_BEACON;
    else if (control_byte_next == wrfc_pkg::FC_PROBE_RESP) kind = wrfc_pkg::KIND_PROBE_RESP;
    else if (control_byte_next == wrfc_pkg::FC_AUTH)       kind = wrfc_pkg::KIND_AUTH;
    else if (control_byte_next == wrfc_pkg::FC_DEAUTH)     kind = wrfc_pkg::KIND_DEAUTH;
    else if (control_byte_next == wrfc_pkg::FC_ASSOC_RESP) kind = wrfc_pkg::KIND_ASSOC_RESP;
    else if ((control_byte_next & wrfc_pkg::FC_TYPE_MASK) == wrfc_pkg::FC_TYPE_DATA)
                                                           kind = wrfc_pkg::KIND_DATA;
    else                                                   kind = wrfc_pkg::KIND_OTHER;

    cnt_inc = '0;
    cnt_inc[wrfc_pkg::CNT_FRAMES]    = 1'b1;
    cnt_inc[wrfc_pkg::CNT_BEACON_AP] = fa && kind == wrfc_pkg::KIND_BEACON;
    cnt_inc[wrfc_pkg::CNT_PROBE_US]  = tu && kind == wrfc_pkg::KIND_PROBE_RESP;
    cnt_inc[wrfc_pkg::CNT_PROBE_AP]  = fa && tu && kind == wrfc_pkg::KIND_PROBE_RESP;
    cnt_inc[wrfc_pkg::CNT_AUTH_AP]   = fa && kind == wrfc_pkg::KIND_AUTH;
    cnt_inc[wrfc_pkg::CNT_DEAUTH_AP] = fa && kind == wrfc_pkg::KIND_DEAUTH;

    eapol_len = len - {{(LEN_W-6){1'b0}}, snap_body_start_next};

    cap_kind          = wrfc_pkg::CAP_NONE;
    cap_start         = '0;
    cap_len           = '0;
    beacon_taken_next = beacon_taken;
    auth_taken_next   = auth_taken;
    assoc_taken_next  = assoc_taken;

    // kinds are exclusive, so at most one arm fires
    if (fa && kind == wrfc_pkg::KIND_BEACON && !beacon_taken
        && len >= LEN_W'(wrfc_pkg::MIN_BEACON_LEN)) begin
      beacon_taken_next = 1'b1;
      cap_kind = wrfc_pkg::CAP_BEACON;
      cap_len  = (len < LEN_W'(wrfc_pkg::BEACON_CAP)) ? len : LEN_W'(wrfc_pkg::BEACON_CAP);
    end else if (fa && tu && kind == wrfc_pkg::KIND_AUTH && !auth_taken) begin
      auth_taken_next = 1'b1;
      cap_kind = wrfc_pkg::CAP_AUTH_RESP;
      cap_len  = (len < LEN_W'(wrfc_pkg::AUTH_CAP)) ? len : LEN_W'(wrfc_pkg::AUTH_CAP);
    end else if (fa && tu && kind == wrfc_pkg::KIND_ASSOC_RESP && !assoc_taken) begin
      assoc_taken_next = 1'b1;
      cap_kind = wrfc_pkg::CAP_ASSOC_RESP;
      cap_len  = (len < LEN_W'(wrfc_pkg::ASSOC_CAP)) ? len : LEN_W'(wrfc_pkg::ASSOC_CAP);
    end else if (fa && tu && kind == wrfc_pkg::KIND_DATA && snap_found_next
                 && len > {{(LEN_W-6){1'b0}}, snap_body_start_next}
                 && eapol_len <= LEN_W'(wrfc_pkg::EAPOL_CAP)) begin
      cap_kind  = wrfc_pkg::CAP_EAPOL;
      cap_start = snap_body_start_next;
      cap_len   = eapol_len;
    end
  end

  // ---------------------------------------------------------------------------
  // State and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      control_byte    <= '0;
      dest_match      <= 1'b1;
      source_match    <= 1'b1;
      snap_found      <= 1'b0;
      snap_body_start <= '0;
      beacon_taken    <= 1'b0;
      auth_taken      <= 1'b0;
      assoc_taken     <= 1'b0;
      out_valid       <= 1'b0;
      for (int i = 0; i < NCNT; i++) begin
        frame_counters[i] <= '0;
      end
    end else begin
      if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        if (is_rearm) begin
          auth_taken  <= 1'b0;
          assoc_taken <= 1'b0;
        end else if (is_last) begin
          // frame done: restart tracking, latch result
          byte_position   <= '0;
          control_byte    <= '0;
          dest_match      <= 1'b1;
          source_match    <= 1'b1;
          snap_found      <= 1'b0;
          snap_body_start <= '0;
          beacon_taken    <= beacon_taken_next;
          auth_taken      <= auth_taken_next;
          assoc_taken     <= assoc_taken_next;
          for (int i = 0; i < NCNT; i++) begin
            frame_counters[i] <= frame_counters[i] + CNT_W'(cnt_inc[i]);
          end
          out_valid <= 1'b1;
        end else begin
          byte_position   <= byte_position_next;
          control_byte    <= control_byte_next;
          dest_match      <= dest_match_next;
          source_match    <= source_match_next;
          snap_found      <= snap_found_next;
          snap_body_start <= snap_body_start_next;
        end
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept && !is_rearm && advance) begin
      byte_window <= {byte_window[47:0], b};
    end
    if (in_accept && is_last) begin
      out_kind      <= kind;
      out_from_ap   <= fa;
      out_to_us     <= tu;
      out_cap_kind  <= cap_kind;
      out_cap_start <= cap_start;
      out_cap_len   <= cap_len[8:0];   // capture length is reported modulo 512
    end
  end

  assign result_ch.valid              = out_valid;
  assign result_ch.frame_kind         = out_kind;
  assign result_ch.from_ap            = out_from_ap;
  assign result_ch.to_us              = out_to_us;
  assign result_ch.capture_kind       = out_cap_kind;
  assign result_ch.capture_start      = out_cap_start;
  assign result_ch.capture_len        = out_cap_len;
  assign result_ch.frames_seen        = frame_counters[wrfc_pkg::CNT_FRAMES];
  assign result_ch.beacons_from_ap    = frame_counters[wrfc_pkg::CNT_BEACON_AP];
  assign result_ch.probe_resp_to_us   = frame_counters[wrfc_pkg::CNT_PROBE_US];
  assign result_ch.probe_resp_from_ap = frame_counters[wrfc_pkg::CNT_PROBE_AP];
  assign result_ch.auth_from_ap       = frame_counters[wrfc_pkg::CNT_AUTH_AP];
  assign result_ch.deauth_from_ap     = frame_counters[wrfc_pkg::CNT_DEAUTH_AP];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WRFC_ASSERT_NEXT(a_last_gives_beat, in_accept && is_last, out_valid,
                    "last byte accepted but no result beat")
  `WRFC_ASSERT_NOW(a_short_is_bare,
                   out_valid && out_kind == wrfc_pkg::KIND_SHORT,
                   out_cap_kind == wrfc_pkg::CAP_NONE && !out_from_ap && !out_to_us,
                   "short frame carries match or capture")
  `WRFC_ASSERT_NOW(a_capture_from_ap,
                   out_valid && out_cap_kind != wrfc_pkg::CAP_NONE, out_from_ap,
                   "capture offered for frame not from AP")
  `WRFC_ASSERT_NEXT(a_beacon_once, beacon_taken, beacon_taken,
                    "beacon capture flag re-armed")

endmodule
